// ----- hdl/bsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared constants and types of the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam logic [7:0]  MarkEsc  = 8'hA5;
  localparam logic [7:0]  MarkHead = 8'hAA;
  localparam logic [7:0]  MarkTail = 8'h55;

  localparam logic [15:0] BufSizeRst = 16'd256;

  // One result word.
  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_data;
    logic        frame_good;
    logic [15:0] frame_length;
    logic        frame_error;
    logic [15:0] errors_seen;
    logic        in_frame;
  } res_t;

  // Stage handshake between the input and the result register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_word_t;

endpackage

// ----- hdl/bsfr_in_reg.sv -----
// ----------------------------------------------------------------------------
// bsfr_in_reg
// Input register: captures one received byte and holds it until decoded.
// ----------------------------------------------------------------------------
module bsfr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               adv_i,
  output bsfr_pkg::in_word_t word_o
);
  import bsfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       accept;

  // Stall only while a held word cannot move on this cycle.
  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// ----- hdl/bsfr_core.sv -----
// ----------------------------------------------------------------------------
// bsfr_core
// Frame state and per-byte decode: header, escape, tail, checksum, overflow.
// ----------------------------------------------------------------------------
module bsfr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [15:0]    buffer_size_i,
  output bsfr_pkg::res_t res_o
);
  import bsfr_pkg::*;

  logic [7:0]  prev_q, prev_d;
  logic [15:0] pos_q, pos_d;
  logic        recv_q, recv_d;
  logic        esc_q, esc_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  newest_q, newest_d;
  logic [7:0]  older_q, older_d;
  logic [15:0] err_cnt_q, err_cnt_d;

  logic [7:0]  tail_sum;
  logic        store;
  logic [7:0]  seen;
  logic        is_head, is_tail, is_esc;

  assign is_head  = (rx_byte_i == MarkHead);
  assign is_tail  = (rx_byte_i == MarkTail);
  assign is_esc   = (rx_byte_i == MarkEsc);
  assign tail_sum = sum_q - (MarkTail + older_q);

  always_comb begin
    prev_d    = prev_q;
    pos_d     = pos_q;
    recv_d    = recv_q;
    esc_d     = esc_q;
    sum_d     = sum_q;
    newest_d  = newest_q;
    older_d   = older_q;
    err_cnt_d = err_cnt_q;
    store     = 1'b0;
    seen      = rx_byte_i;
    res_o     = '0;

    if (is_head && (prev_q == MarkHead)) begin
      // restart on header, keep previous byte
      pos_d  = '0;
      sum_d  = '0;
      esc_d  = 1'b0;
      recv_d = 1'b1;
    end else if (pos_q >= buffer_size_i) begin
      pos_d             = '0;
      sum_d             = '0;
      esc_d             = 1'b0;
      recv_d            = 1'b1;
      err_cnt_d         = err_cnt_q + 16'd1;
      res_o.frame_error = 1'b1;
    end else if (is_tail && (prev_q == MarkTail) && recv_q) begin
      recv_d = 1'b0;
      if (pos_q < 16'd2) begin
        pos_d             = '0;
        sum_d             = '0;
        esc_d             = 1'b0;
        err_cnt_d         = err_cnt_q + 16'd1;
        res_o.frame_error = 1'b1;
      end else if (tail_sum == older_q) begin
        pos_d              = pos_q - 16'd2;
        sum_d              = tail_sum;
        res_o.frame_good   = 1'b1;
        res_o.frame_length = pos_q - 16'd2;
      end else begin
        pos_d             = '0;
        sum_d             = '0;
        esc_d             = 1'b0;
        err_cnt_d         = err_cnt_q + 16'd1;
        res_o.frame_error = 1'b1;
      end
    end else begin
      if (recv_q) begin
        if (esc_q) begin
          if (is_head || is_tail || is_esc) begin
            store = 1'b1;
            esc_d = 1'b0;
            seen  = MarkEsc;
          end else begin
            // bad escape: drop the frame, no error
            pos_d  = '0;
            sum_d  = '0;
            esc_d  = 1'b0;
            recv_d = 1'b0;
          end
        end else if (is_esc) begin
          esc_d = 1'b1;
        end else begin
          store = 1'b1;
        end
      end
      if (store) begin
        res_o.store_valid = 1'b1;
        res_o.store_index = pos_q;
        res_o.store_data  = rx_byte_i;
        pos_d             = pos_q + 16'd1;
        sum_d             = sum_q + rx_byte_i;
        older_d           = newest_q;
        newest_d          = rx_byte_i;
      end
      prev_d = seen;
    end

    res_o.errors_seen = err_cnt_d;
    res_o.in_frame    = recv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      pos_q     <= '0;
      recv_q    <= 1'b0;
      esc_q     <= 1'b0;
      sum_q     <= '0;
      newest_q  <= '0;
      older_q   <= '0;
      err_cnt_q <= '0;
    end else if (adv_i) begin
      prev_q    <= prev_d;
      pos_q     <= pos_d;
      recv_q    <= recv_d;
      esc_q     <= esc_d;
      sum_q     <= sum_d;
      newest_q  <= newest_d;
      older_q   <= older_d;
      err_cnt_q <= err_cnt_d;
    end
  end

endmodule

// ----- hdl/bsfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// bsfr_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module bsfr_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  bsfr_pkg::res_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsfr_pkg::res_t res_o
);
  import bsfr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Free when empty or when the held word leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/byte_stuffed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Deframes a byte-stuffed line stream with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw line byte per word on rx_byte_i, handshake
//   in_valid_i / in_stall_o. Output channel: one result word per input
//   word (store strobe, index and data, frame good with length, frame
//   error, error count, in-frame flag), handshake out_valid_o / out_stall_i.
//   A word is taken at a clock edge with valid high and stall low.
//   Path: a byte is held in the input register, decoded, and its result is
//   loaded into the result register, i.e. one register stage in, one out.
//   Throughput: one byte per clock while out_stall_i is low, set by the single decode stage between
//   the input register and the result register, which also updates the
//   frame state in the same cycle.
//   Reset (rst_ni low, asynchronous) clears the frame state, the error count
//   and both registers, and loads buffer_size with 256.
//   When the receiver stalls, the result register holds its word; the input
//   register holds the next byte, and in_stall_o rises until space frees.
//   User writes buffer_size via buffer_size_we_i only while idle, unenforced.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        buffer_size_we_i,
  input  logic [15:0] buffer_size_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        store_valid_o,
  output logic [15:0] store_index_o,
  output logic [7:0]  store_data_o,
  output logic        frame_good_o,
  output logic [15:0] frame_length_o,
  output logic        frame_error_o,
  output logic [15:0] errors_seen_o,
  output logic        in_frame_o
);
  import bsfr_pkg::*;

  logic [15:0] buffer_size_q;
  in_word_t    in_word;
  logic        out_ready;
  logic        adv;
  res_t        res_next;
  res_t        res_held;

  // Overflow limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BufSizeRst;
    end else if (buffer_size_we_i) begin
      buffer_size_q <= buffer_size_i;
    end
  end

  // Advance the held byte into the result register when there is room.
  assign adv = in_word.valid && out_ready;

  bsfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .word_o     (in_word)
  );

  bsfr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .rx_byte_i     (in_word.data),
    .buffer_size_i (buffer_size_q),
    .res_o         (res_next)
  );

  bsfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res_next),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_held)
  );

  assign store_valid_o  = res_held.store_valid;
  assign store_index_o  = res_held.store_index;
  assign store_data_o   = res_held.store_data;
  assign frame_good_o   = res_held.frame_good;
  assign frame_length_o = res_held.frame_length;
  assign frame_error_o  = res_held.frame_error;
  assign errors_seen_o  = res_held.errors_seen;
  assign in_frame_o     = res_held.in_frame;

endmodule
